FILE: src/lobm_pkg.sv
// Package for the limit order book matcher: sizes, codes and payload structs.
// No dependencies; used by lobm_engine and limit_order_book_matcher_top.
`default_nettype none
package lobm_pkg;

    localparam int MAX_ORDERS = 256;
    localparam int IDX_W      = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
    localparam int CNT_W      = IDX_W + 1;

    localparam logic [2:0] ACT_ADD    = 3'd0;
    localparam logic [2:0] ACT_CANCEL = 3'd1;
    localparam logic [2:0] ACT_MODIFY = 3'd2;
    localparam logic [2:0] ACT_MARKET = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;
    localparam logic [2:0] ACT_QUERY  = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_SHORT   = 2'd3;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef struct packed {
        logic [2:0]  action;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
        logic [31:0] target_id;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] new_order_id;
        logic [31:0] filled_quantity;
        logic [31:0] top_bid;
        logic [31:0] top_ask;
        logic [31:0] spread;
        logic        book_empty;
    } rsp_t;

    typedef struct packed {
        logic        side;
        logic [31:0] price;
        logic [31:0] remaining;
        logic [31:0] ident;
    } slot_t;

    // Engine result before spread and emptiness are derived.
    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [31:0] new_order_id;
        logic [31:0] filled_quantity;
        logic [31:0] bid;
        logic [31:0] ask;
        logic        have_bid;
        logic        have_ask;
    } eng_res_t;

endpackage
`default_nettype wire

FILE: src/lobm_engine.sv
// Order table memory plus scan sequencer for the order book matcher.
// Depends on lobm_pkg.
`default_nettype none
module lobm_engine (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire lobm_pkg::req_t    cmd,
    output logic                   idle,
    output lobm_pkg::eng_res_t     res,
    input  wire logic              res_ready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FREE  = 3'd1;
    localparam logic [2:0] S_FIND  = 3'd2;
    localparam logic [2:0] S_MAKER = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;
    localparam logic [2:0] S_TOB   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    lobm_pkg::slot_t mem [lobm_pkg::MAX_ORDERS];
    lobm_pkg::slot_t rdata_reg;

    logic [2:0]                     state_reg, state_next;
    lobm_pkg::req_t                 cmd_reg, cmd_next;
    logic                           op_side_reg, op_side_next;
    logic [lobm_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                           pv_reg, pv_next;
    logic [lobm_pkg::IDX_W-1:0]     pidx_reg, pidx_next;
    logic                           found_reg, found_next;
    logic [lobm_pkg::IDX_W-1:0]     hit_reg, hit_next;
    lobm_pkg::slot_t                best_reg, best_next;
    logic [31:0]                    left_reg, left_next;
    logic [31:0]                    filled_reg, filled_next;
    logic [1:0]                     status_reg, status_next;
    logic [31:0]                    new_id_reg, new_id_next;
    logic [31:0]                    bid_reg, bid_next;
    logic [31:0]                    ask_reg, ask_next;
    logic                           have_bid_reg, have_bid_next;
    logic                           have_ask_reg, have_ask_next;
    logic [31:0]                    next_ident_reg, next_ident_next;
    logic [lobm_pkg::MAX_ORDERS-1:0] active_reg;

    logic                           set_en, clr_en, clr_all;
    logic [lobm_pkg::IDX_W-1:0]     set_idx, clr_idx;
    logic                           we;
    logic [lobm_pkg::IDX_W-1:0]     waddr;
    lobm_pkg::slot_t                wdata;
    logic                           scanning, issue, scan_end, act, take_side, better;
    logic [31:0]                    fill, rem, ident_inc;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[cnt_reg[lobm_pkg::IDX_W-1:0]];
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        op_side_next    = op_side_reg;
        cnt_next        = cnt_reg;
        pv_next         = 1'b0;
        pidx_next       = pidx_reg;
        found_next      = found_reg;
        hit_next        = hit_reg;
        best_next       = best_reg;
        left_next       = left_reg;
        filled_next     = filled_reg;
        status_next     = status_reg;
        new_id_next     = new_id_reg;
        bid_next        = bid_reg;
        ask_next        = ask_reg;
        have_bid_next   = have_bid_reg;
        have_ask_next   = have_ask_reg;
        next_ident_next = next_ident_reg;
        set_en = 1'b0; set_idx = hit_reg;
        clr_en = 1'b0; clr_idx = hit_reg; clr_all = 1'b0;
        we = 1'b0; waddr = hit_reg; wdata = best_reg;
        fill = 32'd0; rem = 32'd0;
        ident_inc = (next_ident_reg + 32'd1 == 32'd0) ? 32'd1 : next_ident_reg + 32'd1;

        scanning  = (state_reg == S_FREE) || (state_reg == S_FIND) ||
                    (state_reg == S_MAKER) || (state_reg == S_TOB);
        issue     = scanning && (cnt_reg < lobm_pkg::CNT_W'(lobm_pkg::MAX_ORDERS));
        scan_end  = scanning && !issue && !pv_reg;
        act       = active_reg[pidx_reg];
        take_side = ~cmd_reg.side;
        better    = (take_side == lobm_pkg::SIDE_SELL) ? (rdata_reg.price < best_reg.price)
                                                       : (rdata_reg.price > best_reg.price);
        if (issue)
        begin
            cnt_next  = cnt_reg + 1'b1;
            pv_next   = 1'b1;
            pidx_next = cnt_reg[lobm_pkg::IDX_W-1:0];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd;
                    status_next = lobm_pkg::ST_OK;
                    new_id_next = 32'd0;
                    filled_next = 32'd0;
                    cnt_next    = '0;
                    found_next  = 1'b0;
                    unique case (cmd.action) inside
                        lobm_pkg::ACT_ADD:
                        begin
                            op_side_next = cmd.side;
                            if (cmd.quantity == 32'd0)
                            begin
                                new_id_next     = next_ident_reg;
                                next_ident_next = ident_inc;
                                state_next      = S_TOB;
                            end
                            else
                            begin
                                state_next = S_FREE;
                            end
                        end
                        lobm_pkg::ACT_CANCEL, lobm_pkg::ACT_MODIFY:
                        begin
                            state_next = S_FIND;
                        end
                        lobm_pkg::ACT_MARKET:
                        begin
                            left_next  = cmd.quantity;
                            state_next = (cmd.quantity == 32'd0) ? S_TOB : S_MAKER;
                        end
                        lobm_pkg::ACT_CLEAR:
                        begin
                            clr_all    = 1'b1;
                            state_next = S_TOB;
                        end
                        default:
                        begin
                            state_next = S_TOB;
                        end
                    endcase
                    have_bid_next = 1'b0; have_ask_next = 1'b0;
                    bid_next = 32'd0; ask_next = 32'd0;
                end
            end
            S_FREE:
            begin
                if (pv_reg && !found_reg && !act)
                begin
                    found_next = 1'b1;
                    hit_next   = pidx_reg;
                end
                if (scan_end)
                begin
                    cnt_next = '0;
                    if (found_reg)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        status_next = lobm_pkg::ST_FULL;
                        state_next  = S_TOB;
                    end
                end
            end
            S_WRITE:
            begin
                we              = 1'b1;
                wdata           = '{op_side_reg, cmd_reg.price, cmd_reg.quantity,
                                    next_ident_reg};
                set_en          = 1'b1;
                new_id_next     = next_ident_reg;
                next_ident_next = ident_inc;
                cnt_next        = '0;
                state_next      = S_TOB;
            end
            S_FIND:
            begin
                if (pv_reg && !found_reg && act && rdata_reg.ident == cmd_reg.target_id)
                begin
                    found_next = 1'b1;
                    hit_next   = pidx_reg;
                    best_next  = rdata_reg;
                end
                if (scan_end)
                begin
                    cnt_next   = '0;
                    found_next = 1'b0;
                    state_next = S_TOB;
                    if (!found_reg)
                    begin
                        status_next = lobm_pkg::ST_UNKNOWN;
                    end
                    else
                    begin
                        clr_en = 1'b1;
                        if (cmd_reg.action == lobm_pkg::ACT_MODIFY)
                        begin
                            op_side_next = best_reg.side;
                            if (cmd_reg.quantity == 32'd0)
                            begin
                                new_id_next     = next_ident_reg;
                                next_ident_next = ident_inc;
                            end
                            else
                            begin
                                state_next = S_FREE;
                            end
                        end
                    end
                end
            end
            S_MAKER:
            begin
                if (pv_reg && act && rdata_reg.side == take_side)
                begin
                    if (!found_reg || (rdata_reg.price != best_reg.price && better) ||
                        (rdata_reg.price == best_reg.price &&
                         rdata_reg.ident < best_reg.ident))
                    begin
                        found_next = 1'b1;
                        hit_next   = pidx_reg;
                        best_next  = rdata_reg;
                    end
                end
                if (scan_end)
                begin
                    cnt_next = '0;
                    if (found_reg)
                    begin
                        state_next = S_FILL;
                    end
                    else
                    begin
                        status_next = lobm_pkg::ST_SHORT;
                        state_next  = S_TOB;
                    end
                end
            end
            S_FILL:
            begin
                // Take the smaller of maker remainder and taker remainder.
                fill        = (best_reg.remaining < left_reg) ? best_reg.remaining : left_reg;
                rem         = best_reg.remaining - fill;
                we          = 1'b1;
                wdata       = '{best_reg.side, best_reg.price, rem, best_reg.ident};
                clr_en      = (rem == 32'd0);
                left_next   = left_reg - fill;
                filled_next = filled_reg + fill;
                cnt_next    = '0;
                found_next  = 1'b0;
                state_next  = (left_reg != fill) ? S_MAKER : S_TOB;
            end
            S_TOB:
            begin
                if (pv_reg && act)
                begin
                    if (rdata_reg.side == lobm_pkg::SIDE_BUY)
                    begin
                        if (!have_bid_reg || rdata_reg.price > bid_reg)
                        begin
                            bid_next = rdata_reg.price;
                        end
                        have_bid_next = 1'b1;
                    end
                    else
                    begin
                        if (!have_ask_reg || rdata_reg.price < ask_reg)
                        begin
                            ask_next = rdata_reg.price;
                        end
                        have_ask_next = 1'b1;
                    end
                end
                if (scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pv_reg         <= 1'b0;
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            next_ident_reg <= 32'd1;
            active_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pv_reg         <= pv_next;
            cnt_reg        <= cnt_next;
            found_reg      <= found_next;
            next_ident_reg <= next_ident_next;
            if (clr_all)
            begin
                active_reg <= '0;
            end
            else
            begin
                if (clr_en)
                begin
                    active_reg[clr_idx] <= 1'b0;
                end
                if (set_en)
                begin
                    active_reg[set_idx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        op_side_reg  <= op_side_next;
        pidx_reg     <= pidx_next;
        hit_reg      <= hit_next;
        best_reg     <= best_next;
        left_reg     <= left_next;
        filled_reg   <= filled_next;
        status_reg   <= status_next;
        new_id_reg   <= new_id_next;
        bid_reg      <= bid_next;
        ask_reg      <= ask_next;
        have_bid_reg <= have_bid_next;
        have_ask_reg <= have_ask_next;
    end

    assign idle = (state_reg == S_IDLE);
    assign res  = '{(state_reg == S_DONE), status_reg, new_id_reg, filled_reg,
                    bid_reg, ask_reg, have_bid_reg, have_ask_reg};

`ifndef SYNTHESIS
    a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pv_reg)
        else $error("read pipeline busy while idle");
    a_fill_has_maker: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> found_reg)
        else $error("fill without a maker");
    a_ident_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        next_ident_reg != 32'd0)
        else $error("next id is zero");
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start && cmd.action == lobm_pkg::ACT_CLEAR)
        |=> (active_reg == '0))
        else $error("clear left active slots");
`endif

endmodule
`default_nettype wire

FILE: src/limit_order_book_matcher_top.sv
// Top level of the limit order book matcher: request/response handshakes and result register.
// Depends on lobm_pkg and lobm_engine.
`default_nettype none
// One request is worked at a time. The engine walks the order table one entry per cycle
// through its registered read port, and every request ends with a top-of-book sweep.
// A query, clear, zero-lot add or zero-lot market does only that sweep; a cancel, a
// zero-lot modify, an unknown target or an add to a full table first does a search or a
// free-slot sweep; an add that rests adds a table write after its free-slot sweep; a
// modify that rests does a search sweep, a free-slot sweep and a write. A market order
// adds a maker sweep plus a fill step for every resting order it touches, and one more
// maker sweep when it runs short of liquidity. The result sits in an output register, so
// the next request transfer is taken as soon as the engine is idle even while the
// previous response still waits; a second finished result holds the engine until that
// register drains. The active flags reset at once; the rest of the table needs no
// clearing pass.
module limit_order_book_matcher_top (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire lobm_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output lobm_pkg::rsp_t       rsp
);

    logic               eng_idle;
    logic               eng_take;
    lobm_pkg::eng_res_t eng_res;
    logic               rsp_valid_reg;
    lobm_pkg::rsp_t     rsp_reg;
    lobm_pkg::rsp_t     rsp_next;

    // Take a new request whenever the engine is idle.
    assign req_ready = eng_idle;

    // Hand the engine result over when the output register is free or draining.
    assign eng_take = !rsp_valid_reg || rsp_ready;

    lobm_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req_valid && req_ready),
        .cmd       (req),
        .idle      (eng_idle),
        .res       (eng_res),
        .res_ready (eng_take)
    );

    // Derive spread (saturated to zero on a crossed or one-sided book) and emptiness.
    always_comb
    begin
        rsp_next.status          = eng_res.status;
        rsp_next.new_order_id    = eng_res.new_order_id;
        rsp_next.filled_quantity = eng_res.filled_quantity;
        rsp_next.top_bid         = eng_res.bid;
        rsp_next.top_ask         = eng_res.ask;
        rsp_next.spread          = (eng_res.have_bid && eng_res.have_ask &&
                                    eng_res.ask > eng_res.bid) ? eng_res.ask - eng_res.bid
                                                               : 32'd0;
        rsp_next.book_empty      = !eng_res.have_bid && !eng_res.have_ask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (eng_res.valid && eng_take)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Hold the payload until its transfer completes.
    always_ff @(posedge clk)
    begin
        if (eng_res.valid && eng_take)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire
